// ----- hdl/vvs_pkg.sv -----
package vvs_pkg;

  localparam int FRAC_BITS = 16;
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW = $clog2(QUEUE_DEPTH);

  localparam logic [30:0] FIX_ONE = 31'(64'd1 << FRAC_BITS);

  localparam logic [1:0] KIND_POS   = 2'd0;
  localparam logic [1:0] KIND_VEL   = 2'd1;
  localparam logic [1:0] KIND_SCALE = 2'd2;

  localparam logic [1:0] REG_TIME_STEP      = 2'd0;
  localparam logic [1:0] REG_ACCEL_UNITS    = 2'd1;
  localparam logic [1:0] REG_VELOCITY_SCALE = 2'd2;

  localparam logic signed [63:0] S32_MAX = 64'sh0000_0000_7FFF_FFFF;
  localparam logic signed [63:0] S32_MIN = 64'shFFFF_FFFF_8000_0000;

  typedef logic signed [31:0] fix_t;
  typedef fix_t [2:0] vec3_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [9:0]  atom_index;
    fix_t        pos_x;
    fix_t        pos_y;
    fix_t        pos_z;
    fix_t        vel_x;
    fix_t        vel_y;
    fix_t        vel_z;
    fix_t        force_x;
    fix_t        force_y;
    fix_t        force_z;
    logic [30:0] inv_mass;
  } vvs_in_t;

  typedef struct packed {
    logic [9:0] out_index;
    fix_t       result_x;
    fix_t       result_y;
    fix_t       result_z;
    logic       saturated;
  } vvs_out_t;

  typedef struct packed {
    logic [30:0] time_step;
    logic [30:0] accel_units;
    logic [30:0] velocity_scale;
  } vvs_cfg_t;

  typedef struct packed {
    logic pos;
    logic vel;
    logic scale;
  } vvs_op_t;

  typedef struct packed {
    vvs_op_t     op;
    logic        idx_ok;
    logic [9:0]  atom_index;
    logic        ksat;
    logic [30:0] k;
    vec3_t       pos;
    vec3_t       vel;
    vec3_t       frc;
  } vvs_entry_t;

  // Returns {clipped, value}.
  function automatic logic [32:0] sat32(input logic signed [63:0] v);
    logic [32:0] r;
    if (v > S32_MAX) begin
      r = {1'b1, S32_MAX[31:0]};
    end else if (v < S32_MIN) begin
      r = {1'b1, S32_MIN[31:0]};
    end else begin
      r = {1'b0, v[31:0]};
    end
    return r;
  endfunction

  function automatic logic [32:0] add_sat(input fix_t a, input fix_t b);
    return sat32(64'(a) + 64'(b));
  endfunction

  // Exact product, round half up, then clip to 32 bits.
  function automatic logic [32:0] mul_rnd_sat(input fix_t a, input logic [30:0] b);
    logic signed [63:0] prod;
    logic signed [63:0] rnd;
    prod = 64'(a) * $signed({33'd0, b});
    rnd  = (prod + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    return sat32(rnd);
  endfunction

endpackage

// ----- hdl/velocity_verlet_step.sv -----
// Path of a request: input hold register, 4-entry queue, five back stages and output
// register; stalls hold it back.
// Throughput: one request per cycle while the output is not stalled, set by the five-stage
// back pipeline whose registered acceleration store read sits in stage three.
// Reset (rst, synchronous): empties all stages and the queue and sets the three
// registers to 1.0; the acceleration store is not cleared.
module velocity_verlet_step #(
  parameter int MAX_ATOMS = 1024
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  vvs_pkg::vvs_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output vvs_pkg::vvs_out_t out_data,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [30:0]       cfg_data
);

  vvs_pkg::vvs_cfg_t   cfg;
  logic                q_push_valid;
  logic                q_push_ready;
  vvs_pkg::vvs_entry_t q_push_entry;
  logic                q_pop_valid;
  logic                q_pop_ready;
  vvs_pkg::vvs_entry_t q_pop_entry;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '{time_step: vvs_pkg::FIX_ONE, accel_units: vvs_pkg::FIX_ONE,
               velocity_scale: vvs_pkg::FIX_ONE};
    end else if (cfg_we) begin
      unique case (cfg_index)
        vvs_pkg::REG_TIME_STEP:      cfg.time_step <= cfg_data;
        vvs_pkg::REG_ACCEL_UNITS:    cfg.accel_units <= cfg_data;
        vvs_pkg::REG_VELOCITY_SCALE: cfg.velocity_scale <= cfg_data;
        default: ;
      endcase
    end
  end

  vvs_front #(
    .MAX_ATOMS (MAX_ATOMS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .accel_units (cfg.accel_units),
    .q_valid     (q_push_valid),
    .q_ready     (q_push_ready),
    .q_entry     (q_push_entry)
  );

  vvs_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (q_push_valid),
    .push_ready (q_push_ready),
    .push_entry (q_push_entry),
    .pop_valid  (q_pop_valid),
    .pop_ready  (q_pop_ready),
    .pop_entry  (q_pop_entry)
  );

  vvs_back #(
    .MAX_ATOMS (MAX_ATOMS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .pop_valid (q_pop_valid),
    .pop_ready (q_pop_ready),
    .pop_entry (q_pop_entry),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ----- hdl/vvs_ram.sv -----
module vvs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- hdl/vvs_front.sv -----
module vvs_front #(
  parameter int MAX_ATOMS = 1024
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  vvs_pkg::vvs_in_t    in_data,
  input  logic [30:0]         accel_units,
  output logic                q_valid,
  input  logic                q_ready,
  output vvs_pkg::vvs_entry_t q_entry
);

  logic             hold_valid;
  vvs_pkg::vvs_in_t hold;

  logic [61:0] kprod;
  logic [62:0] kround;

  assign in_ready = !hold_valid || q_ready;
  assign q_valid  = hold_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_ready) begin
      hold_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      hold <= in_data;
    end
  end

  always_comb begin
    q_entry.op = '0;
    unique case (hold.kind)
      vvs_pkg::KIND_POS:   q_entry.op.pos = 1'b1;
      vvs_pkg::KIND_VEL:   q_entry.op.vel = 1'b1;
      vvs_pkg::KIND_SCALE: q_entry.op.scale = 1'b1;
      default:             q_entry.op = '0;
    endcase

    // Per-atom factor inv_mass * accel_units, kept non-negative in 31 bits.
    kprod  = 62'(hold.inv_mass) * 62'(accel_units);
    kround = ({1'b0, kprod} + (63'd1 << (vvs_pkg::FRAC_BITS - 1))) >> vvs_pkg::FRAC_BITS;

    q_entry.ksat       = |kround[62:31];
    q_entry.k          = q_entry.ksat ? '1 : kround[30:0];
    q_entry.idx_ok     = 32'(hold.atom_index) < 32'(MAX_ATOMS);
    q_entry.atom_index = hold.atom_index;
    q_entry.pos        = {hold.pos_z, hold.pos_y, hold.pos_x};
    q_entry.vel        = {hold.vel_z, hold.vel_y, hold.vel_x};
    q_entry.frc        = {hold.force_z, hold.force_y, hold.force_x};
  end

endmodule

// ----- hdl/vvs_queue.sv -----
module vvs_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push_valid,
  output logic                push_ready,
  input  vvs_pkg::vvs_entry_t push_entry,
  output logic                pop_valid,
  input  logic                pop_ready,
  output vvs_pkg::vvs_entry_t pop_entry
);

  localparam int AW = vvs_pkg::QUEUE_AW;
  localparam int DEPTH = vvs_pkg::QUEUE_DEPTH;

  vvs_pkg::vvs_entry_t slots [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [AW:0]   count;
  logic          push;
  logic          pop;

  assign push_ready = count != (AW+1)'(DEPTH);
  assign pop_valid  = count != '0;
  assign pop_entry  = slots[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + (AW+1)'(push) - (AW+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

endmodule

// ----- hdl/vvs_back.sv -----
module vvs_back #(
  parameter int MAX_ATOMS = 1024
) (
  input  logic                clk,
  input  logic                rst,
  input  vvs_pkg::vvs_cfg_t   cfg,
  input  logic                pop_valid,
  output logic                pop_ready,
  input  vvs_pkg::vvs_entry_t pop_entry,
  output logic                out_valid,
  input  logic                out_ready,
  output vvs_pkg::vvs_out_t   out_data
);

  localparam int RAM_AW = (MAX_ATOMS > 1) ? $clog2(MAX_ATOMS) : 1;

  typedef struct packed {
    vvs_pkg::vvs_op_t op;
    logic             idx_ok;
    logic [9:0]       atom_index;
    logic             sat;
    vvs_pkg::vec3_t   pos;
    vvs_pkg::vec3_t   vel;
    vvs_pkg::vec3_t   a;
    vvs_pkg::vec3_t   w;
  } stage_t;

  logic adv;
  logic v1, v2, v3, v4, v5;
  vvs_pkg::vvs_entry_t r1;
  stage_t r2, r3, r4, r5;
  stage_t r2_next, r3_next, r4_next, r5_next;
  vvs_pkg::vvs_out_t out_next;

  logic [2:0][32:0] m1, m2, m3, s3, s5;
  logic [30:0]      half;
  vvs_pkg::vec3_t   prev;
  logic             ram_we;
  logic             ram_re;

  // The whole back pipeline moves together; it halts only while a result waits.
  assign adv       = !out_valid || out_ready;
  assign pop_ready = adv;
  assign half      = {1'b0, cfg.time_step[30:1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      v5        <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      v1        <= pop_valid;
      v2        <= v1;
      v3        <= v2;
      v4        <= v3;
      v5        <= v4;
      out_valid <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      r1       <= pop_entry;
      r2       <= r2_next;
      r3       <= r3_next;
      r4       <= r4_next;
      r5       <= r5_next;
      out_data <= out_next;
    end
  end

  // Acceleration from force, or the scaled velocity, on one multiplier per lane.
  always_comb begin
    r2_next.op         = r1.op;
    r2_next.idx_ok     = r1.idx_ok;
    r2_next.atom_index = r1.atom_index;
    r2_next.pos        = r1.pos;
    r2_next.vel        = r1.vel;
    r2_next.w          = '0;
    for (int i = 0; i < 3; i++) begin
      m1[i] = vvs_pkg::mul_rnd_sat(r1.op.scale ? r1.vel[i] : r1.frc[i],
                                   r1.op.scale ? cfg.velocity_scale : r1.k);
      r2_next.a[i] = m1[i][31:0];
    end
    r2_next.sat = (r1.ksat & (r1.op.pos | r1.op.vel))
                | ((m1[0][32] | m1[1][32] | m1[2][32]) & (|r1.op));
  end

  // Position phase stores its acceleration; velocity phase reads it back.
  assign ram_we = adv && v2 && r2.op.pos && r2.idx_ok;
  assign ram_re = adv && v2 && r2.op.vel;

  vvs_ram #(
    .WIDTH ($bits(vvs_pkg::vec3_t)),
    .DEPTH (MAX_ATOMS)
  ) u_accel_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (RAM_AW'(r2.atom_index)),
    .wdata (r2.a),
    .re    (ram_re),
    .raddr (RAM_AW'(r2.atom_index)),
    .rdata (prev)
  );

  always_comb begin
    r3_next = r2;
    for (int i = 0; i < 3; i++) begin
      m2[i] = vvs_pkg::mul_rnd_sat(r2.a[i], half);
      r3_next.w[i] = m2[i][31:0];
    end
    r3_next.sat = r2.sat | (r2.op.pos & (m2[0][32] | m2[1][32] | m2[2][32]));
  end

  // Position phase: vel + a*h/2. Velocity phase: stored + new acceleration. Scale: passed on.
  always_comb begin
    r4_next = r3;
    for (int i = 0; i < 3; i++) begin
      s3[i] = vvs_pkg::add_sat(
                r3.op.pos ? r3.vel[i] : (r3.idx_ok ? prev[i] : vvs_pkg::fix_t'(0)),
                r3.op.pos ? r3.w[i] : r3.a[i]);
      r4_next.w[i] = r3.op.scale ? r3.a[i] : s3[i][31:0];
    end
    r4_next.sat = r3.sat
                | ((r3.op.pos | r3.op.vel) & (s3[0][32] | s3[1][32] | s3[2][32]));
  end

  always_comb begin
    r5_next = r4;
    for (int i = 0; i < 3; i++) begin
      m3[i] = vvs_pkg::mul_rnd_sat(r4.w[i], r4.op.pos ? cfg.time_step : half);
      r5_next.w[i] = r4.op.scale ? r4.w[i] : m3[i][31:0];
    end
    r5_next.sat = r4.sat
                | ((r4.op.pos | r4.op.vel) & (m3[0][32] | m3[1][32] | m3[2][32]));
  end

  always_comb begin
    vvs_pkg::vec3_t res;
    for (int i = 0; i < 3; i++) begin
      s5[i] = vvs_pkg::add_sat(r5.op.pos ? r5.pos[i] : r5.vel[i], r5.w[i]);
      if (r5.op.pos || r5.op.vel) begin
        res[i] = s5[i][31:0];
      end else if (r5.op.scale) begin
        res[i] = r5.w[i];
      end else begin
        res[i] = vvs_pkg::fix_t'(0);
      end
    end
    out_next.out_index = r5.atom_index;
    out_next.result_x  = res[0];
    out_next.result_y  = res[1];
    out_next.result_z  = res[2];
    out_next.saturated = r5.sat
                       | ((r5.op.pos | r5.op.vel) & (s5[0][32] | s5[1][32] | s5[2][32]));
  end

endmodule

// ----- hdl/vvs_checker.sv -----
module vvs_checker (
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input vvs_pkg::vvs_out_t out_data
);

  // Hold register, queue, five back stages and the output register.
  localparam int CAPACITY = vvs_pkg::QUEUE_DEPTH + 7;
  localparam int CW = $clog2(CAPACITY + 1);

  logic [CW-1:0] inflight;
  logic          in_acc;
  logic          out_acc;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      inflight <= '0;
    end else begin
      inflight <= inflight + CW'(in_acc) - CW'(out_acc);
    end
  end

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result offered right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed or dropped");

  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> inflight != '0)
    else $error("result offered with no request outstanding");

  a_bounded: assert property (@(posedge clk) disable iff (rst)
    inflight <= CW'(CAPACITY))
    else $error("more requests outstanding than the pipeline can hold");

endmodule

bind velocity_verlet_step vvs_checker u_vvs_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
